// ===== design/pfra_pkg.sv =====
// ----------------------------------------------------------------------------
// pfra_pkg: shared types and constants of the page frame allocator
// Command and response words, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pfra_pkg;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PG_SHIFT   = 12;
  // page numbers of a 32-bit address space need 20 bits, counts of them 21
  localparam int unsigned PGNUM_W    = ADDR_W - PG_SHIFT;
  localparam logic [ADDR_W-1:0] PG_MASK   = 32'hFFFF_F000;
  localparam logic [ADDR_W-1:0] BASE_RST  = 32'h0010_0000;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RESOLVE = 2'd2;
  localparam logic [1:0] OP_SHARE   = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OOM    = 3'd1;
  localparam logic [2:0] ST_BELOW  = 3'd2;
  localparam logic [2:0] ST_NOPAGE = 3'd3;
  localparam logic [2:0] ST_DOUBLE = 3'd4;
  localparam logic [2:0] ST_EXCL   = 3'd5;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] page_address;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [2:0]        status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/page_frame_refcount_allocator_top.sv =====
// ----------------------------------------------------------------------------
// page_frame_refcount_allocator_top: reference counted page frame allocator
// Per-page 16-bit counts in one memory; a sequencer does read-modify-write
// and scans down from the top page for a free frame on allocation.
// ----------------------------------------------------------------------------
//  channel | ports                    | handshake
//  --------+--------------------------+------------------------------------
//  command | cmd_i                    | taken when start && !busy
//  result  | rsp_o                    | valid for one cycle with done_o
//  config  | cfg_we_i, cfg_wdata_i    | low_mem_base written when cfg_we_i
//
//  Steps from acceptance to the result word:
//  Release / share: locate, read and write back, result; locate and result
//  when the page is below base or past the range. Resolve, exclusive page:
//  locate, read, result. Allocate: locate, then one count memory read per
//  page examined, from the top managed page down. Resolve with copy adds a
//  read step when the old page is managed and a write step when it held a count.
//  After reset a clearing pass over all PAGE_COUNT counts keeps busy high.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_refcount_allocator_top #(
  parameter int unsigned PAGE_COUNT = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire pfra_pkg::cmd_t                 cmd_i,
  output logic                                done_o,
  output pfra_pkg::rsp_t                      rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfra_pkg::ADDR_W-1:0]    cfg_wdata_i
);

  localparam int unsigned IW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned PW = $clog2(PAGE_COUNT + 1);
  localparam int unsigned NW = pfra_pkg::PGNUM_W + 1;
  localparam logic [NW-1:0] PAGES_N   = NW'(PAGE_COUNT);
  localparam logic [IW-1:0] LAST_IDX  = IW'(PAGE_COUNT - 1);
  localparam int unsigned CW = pfra_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOC, S_RD, S_SCAN, S_DEC
  } state_e;

  state_e                       state_q;
  logic [pfra_pkg::ADDR_W-1:0]  base_q;
  pfra_pkg::cmd_t               cmd_q;
  logic [IW-1:0]                clr_q;
  logic [PW-1:0]                left_q;
  logic [IW-1:0]                exam_q;
  logic                         exam_v_q;
  logic                         had_q;
  logic [IW-1:0]                old_idx_q;
  logic [CW-1:0]                old_cnt_q;
  logic [pfra_pkg::ADDR_W-1:0]  new_addr_q;
  logic                         done_q;
  pfra_pkg::rsp_t               rsp_q;

  // memory port
  logic          we;
  logic [IW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [CW-1:0] rdata;

  // locate and effective page count
  logic [pfra_pkg::ADDR_W:0]   diff;
  logic [pfra_pkg::ADDR_W:0]   avail_full;
  logic [NW-1:0]               avail;
  logic [NW-1:0]               eff_n;
  logic [PW-1:0]               eff;
  logic                        below;
  logic                        nopage;
  logic [IW-1:0]               idx;
  logic [pfra_pkg::ADDR_W-1:0] hit_addr;
  logic                        hit;
  logic [IW-1:0]               next_idx;

  always_comb begin
    diff       = {1'b0, cmd_q.page_address} - {1'b0, base_q};
    avail_full = {1'b1, {pfra_pkg::ADDR_W{1'b0}}} - {1'b0, base_q};
    avail      = avail_full[pfra_pkg::ADDR_W:pfra_pkg::PG_SHIFT];
    eff_n      = (avail < PAGES_N) ? avail : PAGES_N;
    eff        = eff_n[PW-1:0];
    below      = diff[pfra_pkg::ADDR_W];
    nopage     = {1'b0, diff[pfra_pkg::ADDR_W-1:pfra_pkg::PG_SHIFT]} >= eff_n;
    idx        = diff[pfra_pkg::PG_SHIFT+IW-1:pfra_pkg::PG_SHIFT];
    hit        = exam_v_q && (rdata == '0);
    hit_addr   = base_q + (pfra_pkg::ADDR_W'(exam_q) << pfra_pkg::PG_SHIFT);
    next_idx   = IW'(left_q - PW'(1));
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    raddr = idx;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
      end
      S_RD: begin
        if (cmd_q.operation == pfra_pkg::OP_RELEASE) begin
          we    = (rdata != '0);
          wdata = rdata - CW'(1);
        end else if (cmd_q.operation == pfra_pkg::OP_SHARE) begin
          we    = 1'b1;
          wdata = (rdata == {CW{1'b1}}) ? rdata : rdata + CW'(1);
        end
      end
      S_SCAN: begin
        raddr = next_idx;
        if (hit) begin
          we    = 1'b1;
          waddr = exam_q;
          wdata = CW'(1);
        end
      end
      S_DEC: begin
        we    = 1'b1;
        waddr = old_idx_q;
        wdata = old_cnt_q - CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      base_q   <= pfra_pkg::BASE_RST;
      clr_q    <= '0;
      left_q   <= '0;
      exam_v_q <= 1'b0;
      had_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == LAST_IDX) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q.operation    <= cmd_i.operation;
            cmd_q.page_address <= (cmd_i.operation == pfra_pkg::OP_RESOLVE)
                                  ? (cmd_i.page_address & pfra_pkg::PG_MASK)
                                  : cmd_i.page_address;
            state_q <= S_LOC;
          end
        end
        S_LOC: begin
          left_q   <= eff;
          exam_v_q <= 1'b0;
          had_q    <= 1'b0;
          old_idx_q <= idx;
          if (cmd_q.operation == pfra_pkg::OP_ALLOC) begin
            state_q <= S_SCAN;
          end else if (below || nopage) begin
            if (cmd_q.operation == pfra_pkg::OP_RESOLVE) begin
              state_q <= S_SCAN;
            end else begin
              done_q  <= 1'b1;
              rsp_q   <= '{result_address: '0,
                           status: below ? pfra_pkg::ST_BELOW : pfra_pkg::ST_NOPAGE};
              state_q <= S_IDLE;
            end
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: begin
          old_cnt_q <= rdata;
          if (cmd_q.operation == pfra_pkg::OP_RESOLVE) begin
            if (rdata == CW'(1)) begin
              done_q  <= 1'b1;
              rsp_q   <= '{result_address: cmd_q.page_address,
                           status: pfra_pkg::ST_EXCL};
              state_q <= S_IDLE;
            end else begin
              had_q   <= (rdata != '0);
              state_q <= S_SCAN;
            end
          end else begin
            done_q  <= 1'b1;
            rsp_q   <= '{result_address: '0,
                         status: (cmd_q.operation == pfra_pkg::OP_RELEASE &&
                                  rdata == '0) ? pfra_pkg::ST_DOUBLE
                                               : pfra_pkg::ST_OK};
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          priority if (hit) begin
            exam_v_q   <= 1'b0;
            new_addr_q <= hit_addr;
            if (had_q) begin
              state_q <= S_DEC;
            end else begin
              done_q  <= 1'b1;
              rsp_q   <= '{result_address: hit_addr, status: pfra_pkg::ST_OK};
              state_q <= S_IDLE;
            end
          end else if (left_q != '0) begin
            exam_q   <= next_idx;
            exam_v_q <= 1'b1;
            left_q   <= left_q - PW'(1);
          end else begin
            exam_v_q <= 1'b0;
            done_q   <= 1'b1;
            rsp_q    <= '{result_address: '0, status: pfra_pkg::ST_OOM};
            state_q  <= S_IDLE;
          end
        end
        S_DEC: begin
          done_q  <= 1'b1;
          rsp_q   <= '{result_address: new_addr_q, status: pfra_pkg::ST_OK};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  pfra_count_ram #(
    .DEPTH (PAGE_COUNT),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // no count update while waiting for a command
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !we) else $error("count write while idle");

  // a word is reported only at the end of an operation
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result while still busy");

  // an accepted command always makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && state_q == S_IDLE) |=> state_q == S_LOC) else $error("command lost");

  // an examined free page is claimed, never skipped
  a_hit_claims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && hit) |-> (we && wdata == CW'(1)))
    else $error("free page not claimed");

endmodule

`default_nettype wire

// ===== design/pfra_count_ram.sv =====
// ----------------------------------------------------------------------------
// pfra_count_ram: reference count memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pfra_count_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [pfra_pkg::CNT_W-1:0] wdata_i,
  input  wire logic [AW-1:0]              raddr_i,
  output logic      [pfra_pkg::CNT_W-1:0] rdata_o
);

  logic [pfra_pkg::CNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
